[hw/rtl/event_log_queue_with_dedup_top_macros.svh]
`ifndef EVENT_LOG_QUEUE_WITH_DEDUP_TOP_MACROS_SVH
`define EVENT_LOG_QUEUE_WITH_DEDUP_TOP_MACROS_SVH

// Invariant checked on every clock outside reset.
`define ELQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ELQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/elq_pkg.sv]
`timescale 1ns / 1ps

package elq_pkg;

    localparam int LOG_DEPTH = 32;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

    localparam int TS_W   = 32;
    localparam int PID_W  = 16;
    localparam int KIND_W = 3;
    localparam int PCT_W  = 7;
    localparam int NOW_W  = 48;
    localparam int SIM_W  = 16;
    localparam int WIN_W  = 24;
    localparam int REC_W  = TS_W + PID_W + KIND_W + PCT_W;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60 * 1000);
    localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(100);

    localparam logic [KIND_W-1:0] KIND_IN   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OUT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TEST = 3'd4;

    localparam logic [1:0] REG_LOG_EN  = 2'd0;
    localparam logic [1:0] REG_SRV_CFG = 2'd1;
    localparam logic [1:0] REG_WINDOW  = 2'd2;

    typedef enum logic [1:0] {
        ACT_REPORT  = 2'd0,
        ACT_PEEK    = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_DROP    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_DISABLED = 3'd1,
        STS_BAD_EVT  = 3'd2,
        STS_NO_TIME  = 3'd3,
        STS_EMPTY    = 3'd4,
        STS_MISMATCH = 3'd5
    } t_status;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    // Input item body, last field in the lowest bits.
    typedef struct packed {
        logic [PCT_W-1:0]        exp_pct;
        logic                    time_ready;
        logic                    checked;
        logic signed [SIM_W-1:0] sim;
        logic [KIND_W-1:0]       kind;
        logic [PID_W-1:0]        pid;
        logic [TS_W-1:0]         ts;
        logic [NOW_W-1:0]        now;
    } t_item;

    localparam int ITEM_W    = $bits(t_item);
    localparam int IN_DATA_W = ((ITEM_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [PCT_W-1:0]  pct;
        logic [KIND_W-1:0] kind;
        logic [PID_W-1:0]  pid;
        logic [TS_W-1:0]   ts;
        logic              dropped;
        logic              dup;
        t_status           status;
    } t_result;

    localparam int RES_W      = $bits(t_result);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic             log_en;
        logic             srv_cfg;
        logic [WIN_W-1:0] window;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]  oldest;
        logic [CNT_W-1:0]  count;
        logic [PID_W-1:0]  last_pid;
        logic [KIND_W-1:0] last_kind;
        logic [NOW_W-1:0]  last_time;
    } t_state;

    typedef struct packed {
        t_result          result;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [REC_W-1:0] wr_data;
        t_state           n_state;
    } t_eval;

endpackage

[hw/rtl/event_log_queue_with_dedup_top.sv]
// Timing: the item and the head slot are registered at the input transfer; the result is
//   registered at write-back, which waits while an earlier result still waits on the output.
// Flow: a new item is taken only after write-back of the last one; the head slot is read from
//   the record RAM in the accept cycle and the item is evaluated and written back after it.
// Reset: synchronous, active low; clears head index, count, last-event tracking, output
//   valid and configuration (window 60000 ms). Record RAM contents are left as they are.
`timescale 1ns / 1ps
`include "event_log_queue_with_dedup_top_macros.svh"

module event_log_queue_with_dedup_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [elq_pkg::WIN_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms, timestamp, badge_id, event_kind, similarity_q, checked_entry,
    // time_ready, expected_pct, zero fill
    input  logic [elq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, duplicate, dropped_oldest, out_timestamp, out_badge_id,
    // out_event_kind, out_similarity_pct, queue_count, zero fill
    output logic [elq_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    elq_pkg::t_fsm      r_state, n_state;
    elq_pkg::t_item     r_item;
    elq_pkg::t_action   r_action;
    elq_pkg::t_cfg      r_cfg;
    elq_pkg::t_state    r_st;
    elq_pkg::t_result   r_result;
    logic               r_m_valid;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_exec;
    logic [elq_pkg::REC_W-1:0]     w_head;
    elq_pkg::t_eval                w_eval;
    logic [elq_pkg::CNT_W-1:0]     w_count;
    logic [elq_pkg::IDX_W-1:0]     w_oldest;

    assign s_axis_tready = (r_state == elq_pkg::FSM_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_exec        = (r_state == elq_pkg::FSM_EXEC) && w_out_free;
    assign w_count       = r_st.count;
    assign w_oldest      = r_st.oldest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_en  <= 1'b0;
            r_cfg.srv_cfg <= 1'b0;
            r_cfg.window  <= elq_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                elq_pkg::REG_LOG_EN:  r_cfg.log_en  <= i_cfg_data[0];
                elq_pkg::REG_SRV_CFG: r_cfg.srv_cfg <= i_cfg_data[0];
                elq_pkg::REG_WINDOW:  r_cfg.window  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= elq_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The next item is taken only after write-back, so a read never overlaps a write.
    always_comb begin
        n_state = r_state;
        case (r_state)
            elq_pkg::FSM_IDLE: begin
                if (w_accept) begin
                    n_state = elq_pkg::FSM_EXEC;
                end
            end
            elq_pkg::FSM_EXEC: begin
                if (w_out_free) begin
                    n_state = elq_pkg::FSM_IDLE;
                end
            end
            default: n_state = elq_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= elq_pkg::t_item'(s_axis_tdata[elq_pkg::ITEM_W-1:0]);
            r_action <= elq_pkg::t_action'(s_axis_tuser);
        end
    end

    elq_ram #(
        .WIDTH (elq_pkg::REC_W),
        .DEPTH (elq_pkg::LOG_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_exec && w_eval.wr_en),
        .i_waddr (w_eval.wr_idx),
        .i_wdata (w_eval.wr_data),
        .i_re    (w_accept),
        .i_raddr (r_st.oldest),
        .o_rdata (w_head)
    );

    elq_eval u_eval (
        .i_action (r_action),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_head   (w_head),
        .o_eval   (w_eval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_exec) begin
            r_st <= w_eval.n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_exec) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_result <= w_eval.result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(elq_pkg::OUT_DATA_W - elq_pkg::RES_W){1'b0}}, r_result};

    `ELQ_ASSERT(a_count_bound, w_count <= elq_pkg::CNT_W'(elq_pkg::LOG_DEPTH), "record count above depth")
    `ELQ_ASSERT(a_oldest_bound, w_oldest <= elq_pkg::IDX_W'(elq_pkg::LOG_DEPTH - 1), "head index out of range")
    `ELQ_ASSERT_NEXT(a_count_idle, r_state == elq_pkg::FSM_IDLE, $stable(w_count), "count moved outside write-back")
    `ELQ_ASSERT_NEXT(a_exec_result, w_exec, m_axis_tvalid && (r_state == elq_pkg::FSM_IDLE), "write-back without result")

endmodule

[hw/rtl/elq_ram.sv]
`timescale 1ns / 1ps

module elq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/elq_eval.sv]
`timescale 1ns / 1ps

module elq_eval (
    input  elq_pkg::t_action                 i_action,
    input  elq_pkg::t_item                   i_item,
    input  elq_pkg::t_cfg                    i_cfg,
    input  elq_pkg::t_state                  i_state,
    input  logic [elq_pkg::REC_W-1:0]        i_head,
    output elq_pkg::t_eval                   o_eval
);

    localparam int SUM_W  = elq_pkg::CNT_W + 1;
    localparam int PROD_W = 21;

    logic                          w_enabled;
    logic                          w_inout;
    logic                          w_full;
    logic                          w_empty;
    logic [elq_pkg::NOW_W:0]       w_diff;
    logic                          w_in_window;
    logic                          w_dup_hit;
    logic [PROD_W-1:0]             w_prod;
    logic [elq_pkg::PCT_W-1:0]     w_pct;
    logic [elq_pkg::IDX_W-1:0]     w_oldest_inc;
    logic [SUM_W-1:0]              w_sum;
    logic [SUM_W-1:0]              w_sum_wrap;
    logic [elq_pkg::REC_W-1:0]     w_expected;
    logic [elq_pkg::TS_W-1:0]      w_store_ts;

    assign w_enabled = i_cfg.log_en & i_cfg.srv_cfg;
    assign w_inout   = (i_item.kind == elq_pkg::KIND_IN) || (i_item.kind == elq_pkg::KIND_OUT);
    assign w_full    = (i_state.count == elq_pkg::CNT_W'(elq_pkg::LOG_DEPTH));
    assign w_empty   = (i_state.count == '0);

    // A borrow out of the top bit means now is earlier than the last record.
    assign w_diff      = {1'b0, i_item.now} - {1'b0, i_state.last_time};
    assign w_in_window = !w_diff[elq_pkg::NOW_W]
                       && (w_diff[elq_pkg::NOW_W-1:0]
                           < {{(elq_pkg::NOW_W - elq_pkg::WIN_W){1'b0}}, i_cfg.window});
    assign w_dup_hit   = w_inout && (i_item.pid == i_state.last_pid)
                       && (i_item.kind == i_state.last_kind) && w_in_window;

    // Q2.14 to percent, round half up; clamp at zero and one.
    assign w_prod = PROD_W'(i_item.sim[13:0]) * PROD_W'(100) + PROD_W'(8192);
    always_comb begin
        if (i_item.sim[15] || (i_item.sim == '0)) begin
            w_pct = '0;
        end else if (i_item.sim[14]) begin
            w_pct = elq_pkg::PCT_FULL;
        end else begin
            w_pct = w_prod[20:14];
        end
    end

    assign w_oldest_inc = (i_state.oldest == elq_pkg::IDX_W'(elq_pkg::LOG_DEPTH - 1))
                        ? '0 : i_state.oldest + elq_pkg::IDX_W'(1);

    // Tail slot; a full log overwrites the head slot.
    assign w_sum      = SUM_W'(i_state.oldest) + SUM_W'(i_state.count);
    assign w_sum_wrap = (w_sum >= SUM_W'(elq_pkg::LOG_DEPTH))
                      ? w_sum - SUM_W'(elq_pkg::LOG_DEPTH) : w_sum;

    assign w_store_ts = i_item.time_ready ? i_item.ts : '0;
    assign w_expected = {i_item.ts, i_item.pid, i_item.kind, i_item.exp_pct};

    always_comb begin
        o_eval                = '0;
        o_eval.result.status  = elq_pkg::STS_OK;
        o_eval.n_state        = i_state;
        o_eval.wr_idx         = w_full ? i_state.oldest : w_sum_wrap[elq_pkg::IDX_W-1:0];
        o_eval.wr_data        = {w_store_ts, i_item.pid, i_item.kind, w_pct};

        case (i_action)
            elq_pkg::ACT_REPORT: begin
                if (i_item.checked && !w_enabled) begin
                    o_eval.result.status = elq_pkg::STS_DISABLED;
                end else if (i_item.checked && !w_inout) begin
                    o_eval.result.status = elq_pkg::STS_BAD_EVT;
                end else if (i_item.checked && !i_item.time_ready) begin
                    o_eval.result.status = elq_pkg::STS_NO_TIME;
                end else if ((i_item.kind != elq_pkg::KIND_TEST) && !w_enabled) begin
                    o_eval.result.status = elq_pkg::STS_DISABLED;
                end else if (i_item.kind > elq_pkg::KIND_TEST) begin
                    o_eval.result.status = elq_pkg::STS_BAD_EVT;
                end else if (w_dup_hit) begin
                    o_eval.result.dup = 1'b1;
                end else begin
                    o_eval.wr_en = 1'b1;
                    if (w_full) begin
                        o_eval.result.dropped  = 1'b1;
                        o_eval.n_state.oldest  = w_oldest_inc;
                    end else begin
                        o_eval.n_state.count = i_state.count + elq_pkg::CNT_W'(1);
                    end
                    o_eval.n_state.last_pid  = i_item.pid;
                    o_eval.n_state.last_kind = i_item.kind;
                    o_eval.n_state.last_time = i_item.now;
                end
            end
            default: begin
                if (w_empty) begin
                    o_eval.result.status = elq_pkg::STS_EMPTY;
                end else begin
                    case (i_action)
                        elq_pkg::ACT_PEEK: begin
                            {o_eval.result.ts, o_eval.result.pid,
                             o_eval.result.kind, o_eval.result.pct} = i_head;
                        end
                        elq_pkg::ACT_ADVANCE: begin
                            if (i_head == w_expected) begin
                                o_eval.n_state.oldest = w_oldest_inc;
                                o_eval.n_state.count  = i_state.count - elq_pkg::CNT_W'(1);
                            end else begin
                                o_eval.result.status = elq_pkg::STS_MISMATCH;
                            end
                        end
                        elq_pkg::ACT_DROP: begin
                            o_eval.n_state.oldest = w_oldest_inc;
                            o_eval.n_state.count  = i_state.count - elq_pkg::CNT_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase

        o_eval.result.count = o_eval.n_state.count;
    end

endmodule

[dv/elq_checker.sv]
`timescale 1ns / 1ps

module elq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [elq_pkg::WIN_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [elq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [elq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_held,
    output logic [elq_pkg::TS_W-1:0]           o_head_ts,
    output logic [elq_pkg::PID_W-1:0]          o_head_pid,
    output logic [elq_pkg::KIND_W-1:0]         o_head_kind,
    output logic [elq_pkg::PCT_W-1:0]          o_head_pct
);
    import elq_pkg::*;

    typedef struct packed {
        logic [TS_W-1:0]   ts;
        logic [PID_W-1:0]  pid;
        logic [KIND_W-1:0] kind;
        logic [PCT_W-1:0]  pct;
    } t_log_rec;

    t_log_rec         slots [LOG_DEPTH];
    logic [IDX_W-1:0] head_idx;
    int               held;
    logic [PID_W-1:0] last_pid;
    logic [KIND_W-1:0] last_kind;
    logic [NOW_W-1:0] last_ms;
    logic             cfg_log_en;
    logic             cfg_srv;
    logic [WIN_W-1:0] cfg_window;
    t_result          results_due [$];
    int               errors = 0;

    assign o_errors = errors;

    function automatic logic [PCT_W-1:0] sim_percent(logic signed [SIM_W-1:0] q);
        logic [31:0] scaled;
        if (q <= 0) return '0;
        if (q >= 16384) return PCT_FULL;
        scaled = 32'(q) * 100 + 8192;
        return PCT_W'(scaled >> 14);
    endfunction

    function automatic void pop_oldest();
        head_idx = IDX_W'((int'(head_idx) + 1) % LOG_DEPTH);
        held--;
    endfunction

    // Advance the log by one transfer and return the result it should produce.
    function automatic t_result apply_to_log(t_action act, t_item it);
        t_result  res;
        t_log_rec head;
        t_log_rec want;
        logic     enabled;
        logic     inout_evt;
        res = '0;
        res.status = STS_OK;
        enabled = cfg_log_en && cfg_srv;
        inout_evt = (it.kind == KIND_IN) || (it.kind == KIND_OUT);
        if (act == ACT_REPORT) begin
            if (it.checked && !enabled) begin
                res.status = STS_DISABLED;
            end else if (it.checked && !inout_evt) begin
                res.status = STS_BAD_EVT;
            end else if (it.checked && !it.time_ready) begin
                res.status = STS_NO_TIME;
            end else if (it.kind != KIND_TEST && !enabled) begin
                res.status = STS_DISABLED;
            end else if (it.kind > KIND_TEST) begin
                res.status = STS_BAD_EVT;
            end else if (inout_evt && it.pid == last_pid && it.kind == last_kind &&
                         it.now >= last_ms &&
                         (it.now - last_ms) < NOW_W'(cfg_window)) begin
                res.dup = 1'b1;
            end else begin
                if (held >= LOG_DEPTH) begin
                    pop_oldest();
                    res.dropped = 1'b1;
                end
                slots[(int'(head_idx) + held) % LOG_DEPTH] =
                    '{ts: it.time_ready ? it.ts : '0, pid: it.pid, kind: it.kind,
                      pct: sim_percent(it.sim)};
                held++;
                last_pid = it.pid;
                last_kind = it.kind;
                last_ms = it.now;
            end
        end else if (held == 0) begin
            res.status = STS_EMPTY;
        end else begin
            head = slots[head_idx];
            want = '{ts: it.ts, pid: it.pid, kind: it.kind, pct: it.exp_pct};
            case (act)
                ACT_PEEK: begin
                    res.ts = head.ts;
                    res.pid = head.pid;
                    res.kind = head.kind;
                    res.pct = head.pct;
                end
                ACT_ADVANCE: begin
                    if (head == want) pop_oldest();
                    else res.status = STS_MISMATCH;
                end
                default: pop_oldest();
            endcase
        end
        res.count = CNT_W'(held);
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            if (errors < 10)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            head_idx = '0;
            held = 0;
            last_pid = '0;
            last_kind = '0;
            last_ms = '0;
            cfg_log_en = 1'b0;
            cfg_srv = 1'b0;
            cfg_window = WINDOW_RESET;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOG_EN:  cfg_log_en = i_cfg_data[0];
                    REG_SRV_CFG: cfg_srv = i_cfg_data[0];
                    REG_WINDOW:  cfg_window = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(apply_to_log(t_action'(s_axis_tuser),
                                                   t_item'(s_axis_tdata[ITEM_W-1:0])));
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[RES_W-1:0]);
                if (results_due.size() == 0) begin
                    check_field("unexpected result", 0, 1);
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("duplicate", want.dup, got.dup);
                    check_field("dropped_oldest", want.dropped, got.dropped);
                    check_field("out_timestamp", want.ts, got.ts);
                    check_field("out_badge_id", want.pid, got.pid);
                    check_field("out_event_kind", want.kind, got.kind);
                    check_field("out_similarity_pct", want.pct, got.pct);
                    check_field("queue_count", want.count, got.count);
                    check_field("zero fill", 0, m_axis_tdata[OUT_DATA_W-1:RES_W]);
                end
            end
        end
        o_pending = results_due.size();
        o_held = held;
        o_head_ts = slots[head_idx].ts;
        o_head_pid = slots[head_idx].pid;
        o_head_kind = slots[head_idx].kind;
        o_head_pct = slots[head_idx].pct;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import elq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 178;
    localparam logic [WIN_W-1:0] WINDOWS [PHASES] =
        '{24'd60000, 24'd0, 24'hFFFFFF, 24'd100, 24'd500, 24'd1, 24'd2000, 24'd30};

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_idx = '0;
    logic [WIN_W-1:0]      i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int                fail_count;
    int                pending;
    int                held;
    logic [TS_W-1:0]   head_ts;
    logic [PID_W-1:0]  head_pid;
    logic [KIND_W-1:0] head_kind;
    logic [PCT_W-1:0]  head_pct;

    bit               steady = 1'b0;
    bit               long_hold = 1'b0;
    logic [NOW_W-1:0] clock_ms = '0;
    int               cycle_count = 0;

    event_log_queue_with_dedup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    elq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_errors      (fail_count),
        .o_pending     (pending),
        .o_held        (held),
        .o_head_ts     (head_ts),
        .o_head_pid    (head_pid),
        .o_head_kind   (head_kind),
        .o_head_pct    (head_pct)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_item make_item(logic [NOW_W-1:0] now, logic [TS_W-1:0] ts,
                                        logic [PID_W-1:0] pid, logic [KIND_W-1:0] kind,
                                        logic signed [SIM_W-1:0] sim, logic checked,
                                        logic tready, logic [PCT_W-1:0] pct);
        t_item it;
        it.now = now;
        it.ts = ts;
        it.pid = pid;
        it.kind = kind;
        it.sim = sim;
        it.checked = checked;
        it.time_ready = tready;
        it.exp_pct = pct;
        return it;
    endfunction

    // Build an advance that names the record currently at the head of the log.
    function automatic t_item oldest_as_item(logic [NOW_W-1:0] now);
        return make_item(now, head_ts, head_pid, head_kind, '0, 1'b0, 1'b0, head_pct);
    endfunction

    task automatic push_item(t_action act, t_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(it);
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        // return after the checker has taken the transfer
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Hold the input until every outstanding result has come back.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [WIN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(int report_weight);
        t_item   it;
        t_action act;
        int      pick;
        int      span;
        int      step;
        it = make_item(NOW_W'({$urandom(), $urandom()}), TS_W'($urandom()),
                       PID_W'($urandom()), KIND_W'($urandom_range(0, 7)),
                       SIM_W'($urandom()), 1'($urandom()), 1'($urandom()),
                       PCT_W'($urandom_range(0, 100)));
        pick = $urandom_range(0, 99);
        span = 100 - report_weight;
        if (pick < report_weight) begin
            act = ACT_REPORT;
            step = $urandom_range(0, 9);
            if (step < 6) clock_ms += NOW_W'($urandom_range(0, 150));
            else if (step < 9) clock_ms += NOW_W'($urandom_range(0, 1 << 22));
            // one report in ten keeps a wild time stamp, possibly behind the last one
            if (step != 9) it.now = clock_ms;
            step = $urandom_range(0, 19);
            if (step < 15) it.kind = step % 2 == 0 ? KIND_IN : KIND_OUT;
            else if (step < 19) it.kind = KIND_W'($urandom_range(2, 4));
            if ($urandom_range(0, 4) != 0) it.pid = PID_W'($urandom_range(0, 3));
            it.checked = $urandom_range(0, 3) == 0;
            it.time_ready = $urandom_range(0, 6) != 0;
            if ($urandom_range(0, 9) < 7) it.sim = SIM_W'($urandom_range(0, 16384));
        end else if (pick - report_weight < span / 3) begin
            act = ACT_PEEK;
        end else if (pick - report_weight < 2 * span / 3) begin
            act = ACT_ADVANCE;
            step = $urandom_range(0, 9);
            if (held > 0 && step < 8) begin
                it = oldest_as_item(it.now);
                // spoil one field so the compare fails
                if (step >= 6) begin
                    case ($urandom_range(0, 3))
                        0: it.ts ^= TS_W'(1) << $urandom_range(0, TS_W - 1);
                        1: it.pid ^= PID_W'(1) << $urandom_range(0, PID_W - 1);
                        2: it.kind = KIND_W'((int'(it.kind) + 1) % 5);
                        default: it.exp_pct = PCT_W'((int'(it.exp_pct) + 1) % 101);
                    endcase
                end
            end
        end else begin
            act = ACT_DROP;
        end
        push_item(act, it);
    endtask

    // Receiver: random stalls per result, one long hold-off when asked.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 7);
            if (long_hold) begin
                stall = 200;
                long_hold = 1'b0;
            end
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Log disabled after reset: empty log, enable gate, test event bypass.
        push_item(ACT_PEEK, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_ADVANCE, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_DROP, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_REPORT, make_item(10, 5, 5, KIND_IN, 100, 1'b0, 1'b1, '0));
        push_item(ACT_REPORT, make_item(20, 5, 5, KIND_TEST, 100, 1'b1, 1'b1, '0));
        push_item(ACT_REPORT, make_item('1, '1, '1, KIND_TEST, 16'sh7FFF, 1'b0, 1'b1, '0));
        push_item(ACT_PEEK, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_ADVANCE, make_item('0, '1, '1, KIND_TEST, '0, 1'b0, 1'b0, 99));
        push_item(ACT_ADVANCE, oldest_as_item('0));

        settle();
        write_reg(REG_LOG_EN, 1);
        write_reg(REG_SRV_CFG, 1);
        write_reg(REG_WINDOW, WINDOW_RESET);

        // Checked gate, unknown kind, duplicate, no wall time, rounding.
        push_item(ACT_REPORT, make_item(900, 7, 9, 3'd2, 100, 1'b1, 1'b1, '0));
        push_item(ACT_REPORT, make_item(900, 7, 9, KIND_IN, 100, 1'b1, 1'b0, '0));
        push_item(ACT_REPORT, make_item(900, 7, 9, 3'd7, 100, 1'b0, 1'b1, '0));
        push_item(ACT_REPORT, make_item(1000, 77, 5, KIND_IN, 16'sh8000, 1'b0, 1'b0, '0));
        push_item(ACT_REPORT, make_item(1500, 78, 5, KIND_IN, 100, 1'b1, 1'b1, '0));
        push_item(ACT_REPORT, make_item(1600, 79, 5, KIND_OUT, 8192, 1'b1, 1'b1, '0));
        push_item(ACT_REPORT, make_item(1700, 80, 5, 3'd3, 1, 1'b0, 1'b1, '0));
        push_item(ACT_REPORT, make_item(1800, 81, 6, 3'd2, 16383, 1'b0, 1'b1, '0));
        push_item(ACT_REPORT, make_item(1900, 82, 0, KIND_IN, 82, 1'b0, 1'b1, 100));
        push_item(ACT_PEEK, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_DROP, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        push_item(ACT_ADVANCE, oldest_as_item('0));
        push_item(ACT_PEEK, make_item('0, '0, '0, KIND_IN, '0, 1'b0, 1'b0, '0));
        clock_ms = 2000;

        for (int phase = 0; phase < PHASES; phase++) begin
            int report_weight;
            settle();
            write_reg(REG_LOG_EN, WIN_W'(phase != 3 && phase != 5));
            write_reg(REG_SRV_CFG, WIN_W'(phase != 4 && phase != 5));
            write_reg(REG_WINDOW, WINDOWS[phase]);
            report_weight = phase % 3 == 0 ? 55 : (phase % 3 == 1 ? 80 : 30);
            steady = 1'b1;
            if (phase == 2) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == 30 && phase != 2) steady = 1'b0;
                if (n == 80) steady = 1'b0;
                if (n == 100) settle();
                send_random(report_weight);
            end
            steady = 1'b0;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
